[rtl/whs_pkg.sv]
// Package for the weight hold step sequencer: field widths, request,
// step kind, phase and register codes, and the packed step table entry.
// No dependencies; every other file of the block takes names from here.
package whs_pkg;

    // Table depth default and fixed field widths
    localparam int MAX_STEPS_DEF = 16;
    localparam int STEP_W        = 4;
    localparam int WEIGHT_W      = 32;
    localparam int BAND_W        = 31;
    localparam int TIME_W        = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_COUNT = 1'b0,
        CFG_REPEAT     = 1'b1
    } cfg_reg_t;

    // Request codes carried in req_type
    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_kind_t;

    // Step kinds
    typedef enum logic {
        KIND_WAIT = 1'b0,
        KIND_HOLD = 1'b1
    } step_kind_t;

    // Step phase: start, drive across target, timed hold
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SEEK  = 2'd1,
        PH_HOLD  = 2'd2
    } phase_t;

    // One program step as stored in the step table
    typedef struct packed {
        step_kind_t                 kind;
        logic signed [WEIGHT_W-1:0] target;
        logic [BAND_W-1:0]          band;
        logic [TIME_W-1:0]          hold_ms;
    } step_entry_t;

    // One accepted request as held in the input register
    typedef struct packed {
        req_kind_t                  req_type;
        logic [STEP_W-1:0]          step_slot;
        step_entry_t                entry;
        logic signed [WEIGHT_W-1:0] weight;
        logic [TIME_W-1:0]          now_ms;
    } req_item_t;

endpackage

[rtl/whs_if.sv]
// Valid/ready channel interfaces for the request and result sides of the
// weight hold step sequencer. Depends on whs_pkg for field widths.
interface whs_req_if;
    logic                               valid;
    logic                               ready;
    logic                               req_type;
    logic [whs_pkg::STEP_W-1:0]         step_slot;
    logic                               step_kind;
    logic signed [whs_pkg::WEIGHT_W-1:0] step_target;
    logic [whs_pkg::BAND_W-1:0]         step_band;
    logic [whs_pkg::TIME_W-1:0]         step_hold_ms;
    logic signed [whs_pkg::WEIGHT_W-1:0] weight;
    logic [whs_pkg::TIME_W-1:0]         now_ms;

    modport source (
        output valid, req_type, step_slot, step_kind, step_target, step_band,
               step_hold_ms, weight, now_ms,
        input  ready
    );
    modport sink (
        input  valid, req_type, step_slot, step_kind, step_target, step_band,
               step_hold_ms, weight, now_ms,
        output ready
    );
endinterface

interface whs_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       water;
    logic                       step_done;
    logic                       protocol_done;
    logic [whs_pkg::STEP_W-1:0] current_step;

    modport source (
        output valid, water, step_done, protocol_done, current_step,
        input  ready
    );
    modport sink (
        input  valid, water, step_done, protocol_done, current_step,
        output ready
    );
endinterface

[rtl/whs_step_mem.sv]
// Step table memory: one write port, one read port with registered data.
// A write to the address being read is forwarded to the read data.
// Depends on whs_pkg for the entry type.
module whs_step_mem #(
    parameter int DEPTH = whs_pkg::MAX_STEPS_DEF
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  whs_pkg::step_entry_t                     wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output whs_pkg::step_entry_t                     rd_data
);

    whs_pkg::step_entry_t step_mem [DEPTH];
    whs_pkg::step_entry_t rd_data_reg;

    // Write the table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            step_mem[wr_addr] <= wr_data;
        end
    end

    // Read every cycle, forward a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= step_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/weight_hold_step_sequencer_top.sv]
// Weight hold step sequencer, top level: input register, step evaluation,
// result register and program state. Depends on whs_pkg, whs_if and
// whs_step_mem.
//
// Usage:
//   req carries transactions of two kinds. A load (req_type 0) writes one
//   program step into the step table at step_slot. A sample (req_type 1)
//   runs the active step against weight and now_ms.
//   rsp returns exactly one transaction per request: water, step_done,
//   protocol_done and the step pointer after the request.
//   cfg_we/cfg_index/cfg_data write step_count and repeat_program; write
//   them only while no request is in flight.
// Pipeline: an accepted request waits in the input register, is evaluated
//   from there, and its result is captured in the result register once
//   that register is empty or its result is being taken by rsp.
// Throughput: one request per cycle while rsp is ready. The step table
//   read for the next request starts at the edge updating the step pointer.
// Reset: pointer, phase, timer and flags clear, step_count is 1,
//   repeat_program is 0. The step table is not cleared; load every step
//   that the program runs before the first sample.
// Stall: when rsp is held not ready, the result register holds, one more
//   request is taken into the input register, then req.ready drops.
module weight_hold_step_sequencer_top #(
    parameter int MAX_STEPS = whs_pkg::MAX_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    whs_req_if.sink                         req,
    whs_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [whs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [whs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CW = (AW + 1 > whs_pkg::STEP_W + 1) ? AW + 1 : whs_pkg::STEP_W + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(MAX_STEPS);
    localparam int MOD_STEPS = 8;
    localparam int XW = whs_pkg::WEIGHT_W + 2;

    // Reduce a step pointer to a table address by repeated subtraction
    function automatic logic [AW-1:0] slot_addr(input logic [whs_pkg::STEP_W-1:0] p);
        logic [CW-1:0] v;
        v = CW'(p);
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            if (v >= DEPTH_C)
            begin
                v = v - DEPTH_C;
            end
        end
        return v[AW-1:0];
    endfunction

    // Pipeline control
    logic                  in_valid_reg;
    whs_pkg::req_item_t    item_reg;
    logic                  rsp_valid_reg;
    logic                  advance;

    // Result registers
    logic                        water_reg;
    logic                        step_done_reg;
    logic                        pdone_reg;
    logic [whs_pkg::STEP_W-1:0]  cur_step_reg;

    // Program state and configuration
    logic [whs_pkg::STEP_W-1:0]  ptr_reg, ptr_next;
    logic                        completed_reg, completed_next;
    whs_pkg::phase_t             phase_reg, phase_next;
    logic [whs_pkg::TIME_W-1:0]  timer_reg, timer_next;
    logic                        heavier_reg, heavier_next;
    logic [whs_pkg::STEP_W-1:0]  count_reg, count_next;
    logic                        repeat_reg, repeat_next;

    // Step table
    whs_pkg::step_entry_t        entry;
    logic                        tbl_we;
    logic [AW-1:0]               tbl_rd_addr;
    logic [whs_pkg::STEP_W-1:0]  ptr_upd;

    // Evaluation terms
    logic                        pdone_cur;
    logic                        run;
    logic [whs_pkg::STEP_W-1:0]  ptr0;
    logic [whs_pkg::STEP_W-1:0]  ptr_inc;
    logic                        end_of_prog;
    logic signed [XW-1:0]        w_x, tgt_x, band_x, hi_x, lo_x;
    logic                        in_band;
    logic                        below_lo;
    logic                        dur_zero;
    logic                        timer_done;
    logic                        at_start;
    whs_pkg::phase_t             hold_phase;
    logic                        heavier_eff;
    logic                        crossed;
    logic                        hold_elapsed;
    logic                        fire;
    logic                        water_c;
    logic                        pdone_out;

    // Handshake: move the input register into the result register
    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.req_type      <= whs_pkg::req_kind_t'(req.req_type);
            item_reg.step_slot     <= req.step_slot;
            item_reg.entry.kind    <= whs_pkg::step_kind_t'(req.step_kind);
            item_reg.entry.target  <= req.step_target;
            item_reg.entry.band    <= req.step_band;
            item_reg.entry.hold_ms <= req.step_hold_ms;
            item_reg.weight        <= req.weight;
            item_reg.now_ms        <= req.now_ms;
        end
    end

    // Step table, addressed by the pointer the next request will see
    assign tbl_we = advance && (item_reg.req_type == whs_pkg::REQ_LOAD)
                    && (CW'(item_reg.step_slot) < DEPTH_C);
    assign ptr_upd = advance ? ptr_next : ptr_reg;
    assign tbl_rd_addr = slot_addr((ptr_upd >= count_next) ? '0 : ptr_upd);

    whs_step_mem #(
        .DEPTH (MAX_STEPS)
    ) u_step_mem (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (AW'(item_reg.step_slot)),
        .wr_data (item_reg.entry),
        .rd_addr (tbl_rd_addr),
        .rd_data (entry)
    );

    // Configuration next values
    always_comb
    begin
        count_next  = count_reg;
        repeat_next = repeat_reg;
        if (cfg_we)
        begin
            unique case (whs_pkg::cfg_reg_t'(cfg_index))
                whs_pkg::CFG_STEP_COUNT: count_next  = cfg_data[whs_pkg::STEP_W-1:0];
                whs_pkg::CFG_REPEAT:     repeat_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    // Evaluate the active step
    always_comb
    begin
        pdone_cur   = completed_reg && !repeat_reg;
        run         = (item_reg.req_type == whs_pkg::REQ_SAMPLE) && !pdone_cur;
        ptr0        = (ptr_reg >= count_reg) ? '0 : ptr_reg;
        ptr_inc     = ptr0 + whs_pkg::STEP_W'(1);
        end_of_prog = ptr_inc >= count_reg;

        w_x      = XW'(item_reg.weight);
        tgt_x    = XW'(entry.target);
        band_x   = signed'(XW'(entry.band));
        hi_x     = tgt_x + band_x;
        lo_x     = tgt_x - band_x;
        in_band  = (w_x <= hi_x) && (w_x >= lo_x);
        below_lo = w_x < lo_x;

        dur_zero   = entry.hold_ms == '0;
        timer_done = (item_reg.now_ms - timer_reg) >= entry.hold_ms;
        at_start   = phase_reg == whs_pkg::PH_START;

        hold_phase   = phase_reg;
        heavier_eff  = heavier_reg;
        hold_elapsed = timer_done;
        if (at_start)
        begin
            hold_elapsed = dur_zero;
            if (in_band)
            begin
                hold_phase = whs_pkg::PH_HOLD;
            end
            else
            begin
                hold_phase  = whs_pkg::PH_SEEK;
                heavier_eff = item_reg.weight <= entry.target;
            end
        end
        crossed = heavier_eff ? (item_reg.weight > entry.target)
                              : (item_reg.weight < entry.target);
    end

    // Outputs of the step: finish and water request
    always_comb
    begin
        fire    = 1'b0;
        water_c = 1'b0;
        if (run)
        begin
            if (entry.kind == whs_pkg::KIND_WAIT)
            begin
                fire = dur_zero || (!at_start && timer_done);
            end
            else
            begin
                unique case (hold_phase)
                    whs_pkg::PH_SEEK:
                    begin
                        fire    = crossed && dur_zero;
                        water_c = !crossed && (entry.target > item_reg.weight);
                    end
                    whs_pkg::PH_HOLD:
                    begin
                        fire    = hold_elapsed;
                        water_c = !hold_elapsed && below_lo;
                    end
                    default: ;
                endcase
            end
        end
        pdone_out = pdone_cur || (fire && end_of_prog && !repeat_reg);
    end

    // Next program state
    always_comb
    begin
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        heavier_next   = heavier_reg;
        ptr_next       = ptr_reg;
        completed_next = completed_reg;
        if (run)
        begin
            ptr_next = ptr0;
            if (entry.kind == whs_pkg::KIND_WAIT)
            begin
                if (!dur_zero && at_start)
                begin
                    timer_next = item_reg.now_ms;
                    phase_next = whs_pkg::PH_SEEK;
                end
            end
            else
            begin
                heavier_next = heavier_eff;
                phase_next   = hold_phase;
                if (at_start && in_band)
                begin
                    timer_next = item_reg.now_ms;
                end
                if ((hold_phase == whs_pkg::PH_SEEK) && crossed && !dur_zero)
                begin
                    timer_next = item_reg.now_ms;
                    phase_next = whs_pkg::PH_HOLD;
                end
            end
            if (fire)
            begin
                phase_next = whs_pkg::PH_START;
                ptr_next   = ptr_inc;
                if (end_of_prog)
                begin
                    completed_next = 1'b1;
                    if (repeat_reg)
                    begin
                        ptr_next = '0;
                    end
                end
            end
        end
    end

    // Hold program state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            completed_reg <= 1'b0;
            phase_reg     <= whs_pkg::PH_START;
            timer_reg     <= '0;
            heavier_reg   <= 1'b0;
            count_reg     <= whs_pkg::STEP_W'(1);
            repeat_reg    <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            repeat_reg <= repeat_next;
            if (advance)
            begin
                ptr_reg       <= ptr_next;
                completed_reg <= completed_next;
                phase_reg     <= phase_next;
                timer_reg     <= timer_next;
                heavier_reg   <= heavier_next;
            end
        end
    end

    // Result valid: set on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            water_reg     <= water_c;
            step_done_reg <= fire;
            pdone_reg     <= pdone_out;
            cur_step_reg  <= ptr_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.water         = water_reg;
    assign rsp.step_done     = step_done_reg;
    assign rsp.protocol_done = pdone_reg;
    assign rsp.current_step  = cur_step_reg;

endmodule

[rtl/whs_checker.sv]
// Port-level checks for the weight hold step sequencer, attached to the
// top level by the bind below. Depends on whs_pkg for field widths.
module whs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        water,
    input logic                        step_done,
    input logic                        protocol_done,
    input logic [whs_pkg::STEP_W-1:0]  current_step
);

    // Stalled result holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(water) && $stable(step_done)
            && $stable(protocol_done) && $stable(current_step))
        else $error("result changed while stalled");

    // A finishing step never requests water
    a_done_dry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(water && step_done))
        else $error("water requested on a finishing step");

    // A finished program never requests water
    a_pdone_dry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(water && protocol_done))
        else $error("water requested after program end");

    // Completing the program leaves the pointer past step zero
    a_end_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && step_done && protocol_done |-> current_step != '0)
        else $error("program completed with pointer at zero");

endmodule

bind weight_hold_step_sequencer_top whs_checker u_whs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .water         (rsp.water),
    .step_done     (rsp.step_done),
    .protocol_done (rsp.protocol_done),
    .current_step  (rsp.current_step)
);

[tb/tb_weight_hold_step_sequencer_top.sv]
`timescale 1ns / 1ps
// Testbench for weight_hold_step_sequencer_top: a directed stimulus table, then random
// step loads and weight samples, each result checked against an in-bench predictor.
// Depends on whs_pkg, whs_if and the sequencer RTL.
module tb_weight_hold_step_sequencer_top;

    localparam int STEP_W        = whs_pkg::STEP_W;
    localparam int WEIGHT_W      = whs_pkg::WEIGHT_W;
    localparam int BAND_W        = whs_pkg::BAND_W;
    localparam int TIME_W        = whs_pkg::TIME_W;
    localparam int CFG_IDX_W     = whs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = whs_pkg::CFG_DATA_W;
    localparam int MAX_STEPS_DEF = whs_pkg::MAX_STEPS_DEF;

    localparam int CLK_HALF        = 4;
    localparam int RST_CYCLES      = 11;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int N_DIR           = 25;
    localparam int N_PHASES        = 8;
    localparam int PHASE_ITEMS     = 175;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;

    typedef whs_pkg::req_item_t   req_item_t;
    typedef whs_pkg::step_entry_t step_entry_t;
    typedef whs_pkg::step_kind_t  step_kind_t;
    typedef whs_pkg::phase_t      phase_t;

    // One result transaction as seen on rsp
    typedef struct packed {
        logic              water;
        logic              step_done;
        logic              protocol_done;
        logic [STEP_W-1:0] current_step;
    } seq_rsp_t;

    // One row of the directed table: a register setting or a request
    typedef struct {
        bit                is_cfg;
        logic [STEP_W-1:0] cfg_count;
        logic              cfg_repeat;
        req_item_t         item;
        bit                typed;
        seq_rsp_t          want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    whs_req_if req();
    whs_rsp_if rsp();

    weight_hold_step_sequencer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted program state and register copies
    step_entry_t       prog_tbl [MAX_STEPS_DEF];
    logic [STEP_W-1:0] ptr_q;
    logic              completed_q;
    phase_t            phase_q;
    logic [TIME_W-1:0] timer_q;
    logic              heavier_q;
    logic [STEP_W-1:0] count_q;
    logic              repeat_q;

    seq_rsp_t          expected_rsp [$];
    int                fail_count;
    int                cycle_count;
    int                src_idle_pct;
    int                snk_stall_pct;
    bit                hold_off_req;
    logic [TIME_W-1:0] clock_ms;
    dir_row_t          dir_tbl [N_DIR];

    // Evaluate the active step on one sample; return 1 when the step finishes
    function automatic logic run_active_step(input step_entry_t st, input longint w,
                                             input logic [TIME_W-1:0] now,
                                             output logic water);
        longint tgt;
        longint bnd;
        tgt = longint'($signed(st.target));
        bnd = longint'({1'b0, st.band});
        water = 1'b0;
        if (st.kind == whs_pkg::KIND_WAIT)
        begin
            if (st.hold_ms == 0)
                return 1'b1;
            if (phase_q == whs_pkg::PH_START)
            begin
                timer_q = now;
                phase_q = whs_pkg::PH_SEEK;
                return 1'b0;
            end
            return (now - timer_q) >= st.hold_ms;
        end
        // Hold step: start, then drive across target, then timed hold
        if (phase_q == whs_pkg::PH_START)
        begin
            if (w <= tgt + bnd && w >= tgt - bnd)
            begin
                timer_q = now;
                phase_q = whs_pkg::PH_HOLD;
            end
            else
            begin
                heavier_q = (w <= tgt);
                phase_q   = whs_pkg::PH_SEEK;
            end
        end
        if (phase_q == whs_pkg::PH_SEEK)
        begin
            if ((heavier_q && w > tgt) || (!heavier_q && w < tgt))
            begin
                if (st.hold_ms == 0)
                    return 1'b1;
                timer_q = now;
                phase_q = whs_pkg::PH_HOLD;
            end
            else
                water = (tgt > w);
        end
        else if (phase_q == whs_pkg::PH_HOLD)
        begin
            if ((now - timer_q) >= st.hold_ms)
                return 1'b1;
            if (w < tgt - bnd)
                water = 1'b1;
        end
        return 1'b0;
    endfunction

    // Compute the result of one request and advance the predicted state
    function automatic seq_rsp_t compute_response(input req_item_t it);
        seq_rsp_t r;
        logic     fin;
        logic     wat;
        r = '0;
        r.protocol_done = completed_q && !repeat_q;
        if (it.req_type == whs_pkg::REQ_LOAD)
            prog_tbl[it.step_slot] = it.entry;
        else if (!r.protocol_done)
        begin
            if (ptr_q >= count_q)
                ptr_q = '0;
            fin = run_active_step(prog_tbl[ptr_q], longint'($signed(it.weight)), it.now_ms, wat);
            r.water = wat;
            if (fin)
            begin
                r.step_done = 1'b1;
                phase_q     = whs_pkg::PH_START;
                ptr_q       = ptr_q + 1'b1;
                if (ptr_q >= count_q)
                begin
                    completed_q = 1'b1;
                    if (!repeat_q)
                        r.protocol_done = 1'b1;
                    else
                        ptr_q = '0;
                end
            end
        end
        r.current_step = ptr_q;
        return r;
    endfunction

    // Directed table row builders
    function automatic dir_row_t blank_row();
        dir_row_t r;
        r.is_cfg     = 1'b0;
        r.cfg_count  = '0;
        r.cfg_repeat = 1'b0;
        r.item       = '0;
        r.typed      = 1'b0;
        r.want       = '0;
        return r;
    endfunction

    function automatic dir_row_t ld(input logic [STEP_W-1:0] slot, input step_kind_t kind,
                                    input logic [WEIGHT_W-1:0] tgt,
                                    input logic [BAND_W-1:0] band,
                                    input logic [TIME_W-1:0] hold);
        dir_row_t r;
        r = blank_row();
        r.item.req_type      = whs_pkg::REQ_LOAD;
        r.item.step_slot     = slot;
        r.item.entry.kind    = kind;
        r.item.entry.target  = tgt;
        r.item.entry.band    = band;
        r.item.entry.hold_ms = hold;
        return r;
    endfunction

    function automatic dir_row_t smp(input logic [WEIGHT_W-1:0] w, input logic [TIME_W-1:0] now);
        dir_row_t r;
        r = blank_row();
        r.item.req_type = whs_pkg::REQ_SAMPLE;
        r.item.weight   = w;
        r.item.now_ms   = now;
        return r;
    endfunction

    function automatic dir_row_t cfg(input logic [STEP_W-1:0] n, input logic rpt);
        dir_row_t r;
        r = blank_row();
        r.is_cfg     = 1'b1;
        r.cfg_count  = n;
        r.cfg_repeat = rpt;
        return r;
    endfunction

    function automatic dir_row_t with_result(input dir_row_t r, input logic wat, input logic dn,
                                             input logic pd, input logic [STEP_W-1:0] st);
        r.typed = 1'b1;
        r.want  = {wat, dn, pd, st};
        return r;
    endfunction

    // Build one load with mostly moderate values, other fields random
    function automatic req_item_t make_load(input logic [STEP_W-1:0] slot);
        req_item_t it;
        it.req_type      = whs_pkg::REQ_LOAD;
        it.step_slot     = slot;
        it.entry.kind    = step_kind_t'($urandom_range(0, 1));
        it.entry.target  = $urandom;
        it.entry.band    = BAND_W'($urandom);
        it.entry.hold_ms = $urandom;
        it.weight        = $urandom;
        it.now_ms        = $urandom;
        if ($urandom_range(0, 99) < 85)
        begin
            it.entry.target = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            it.entry.band   = BAND_W'($urandom_range(0, 4096));
            it.entry.hold_ms = ($urandom_range(0, 99) < 15) ? 32'd0 : $urandom_range(1, 40);
        end
        else if ($urandom_range(0, 99) < 65)
            it.entry.hold_ms = $urandom_range(0, 40);
        return it;
    endfunction

    // Build one random request: mostly samples near the active target
    function automatic req_item_t random_item();
        req_item_t         it;
        logic [STEP_W-1:0] idx;
        longint            tgt;
        longint            w;
        int unsigned       spn;
        idx = (ptr_q >= count_q) ? '0 : ptr_q;
        if ($urandom_range(0, 99) < 12)
        begin
            // Reload the active slot now and then, otherwise any slot
            return make_load(($urandom_range(0, 99) < 30) ? idx : STEP_W'($urandom_range(0, 15)));
        end
        it.req_type      = whs_pkg::REQ_SAMPLE;
        it.step_slot     = STEP_W'($urandom_range(0, 15));
        it.entry.kind    = step_kind_t'($urandom_range(0, 1));
        it.entry.target  = $urandom;
        it.entry.band    = BAND_W'($urandom);
        it.entry.hold_ms = $urandom;
        it.weight        = $urandom;
        if ($urandom_range(0, 99) >= 10)
        begin
            tgt = longint'($signed(prog_tbl[idx].target));
            spn = (prog_tbl[idx].band > 31'h0010_0000) ? 32'h0010_0000 : prog_tbl[idx].band;
            spn = spn + 32;
            w = tgt + longint'($urandom_range(0, 4 * spn)) - 2 * longint'(spn);
            it.weight = w[WEIGHT_W-1:0];
        end
        // Advance time in small steps, jump now and then
        if ($urandom_range(0, 99) < 3)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 12);
        it.now_ms = clock_ms;
        return it;
    endfunction

    // Offer one request transaction and predict its result on acceptance
    task automatic send_item(input req_item_t it, input bit typed, input seq_rsp_t want);
        seq_rsp_t pred;
        while (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid        <= 1'b1;
        req.req_type     <= it.req_type;
        req.step_slot    <= it.step_slot;
        req.step_kind    <= it.entry.kind;
        req.step_target  <= it.entry.target;
        req.step_band    <= it.entry.band;
        req.step_hold_ms <= it.entry.hold_ms;
        req.weight       <= it.weight;
        req.now_ms       <= it.now_ms;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pred = compute_response(it);
        expected_rsp.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_idle();
        req.valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // Write both registers while idle and update the predicted copies
    task automatic program_regs(input logic [STEP_W-1:0] n, input logic rpt);
        cfg_we    <= 1'b1;
        cfg_index <= whs_pkg::CFG_STEP_COUNT;
        cfg_data  <= n;
        @(negedge clk);
        cfg_index <= whs_pkg::CFG_REPEAT;
        cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, rpt};
        @(negedge clk);
        cfg_we   <= 1'b0;
        count_q  = n;
        repeat_q = rpt;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Timeout
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL weight_hold_step_sequencer_top");
        $finish;
    end

    // Result receiver: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        rsp.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_taken)
            begin
                hold_left  = HOLD_OFF_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= !(snk_stall_pct != 0 && $urandom_range(1, 100) <= snk_stall_pct);
        end
    end

    // Compare each accepted result transaction with the oldest prediction
    always @(posedge clk)
    begin
        seq_rsp_t got;
        seq_rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = {rsp.water, rsp.step_done, rsp.protocol_done, rsp.current_step};
            if (expected_rsp.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("error: unexpected result water=%0b done=%0b pdone=%0b step=%0d",
                             got.water, got.step_done, got.protocol_done, got.current_step);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (got.water !== want.water || got.step_done !== want.step_done ||
                    got.protocol_done !== want.protocol_done ||
                    got.current_step !== want.current_step)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"error: result mismatch expected water=%0b done=%0b ",
                                  "pdone=%0b step=%0d, got water=%0b done=%0b pdone=%0b step=%0d"},
                                 want.water, want.step_done, want.protocol_done,
                                 want.current_step, got.water, got.step_done,
                                 got.protocol_done, got.current_step);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [STEP_W-1:0] n_steps;
        logic              rpt;

        // Known values on every input, reset predicted state
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = whs_pkg::CFG_STEP_COUNT;
        cfg_data         = '0;
        req.valid        = 1'b0;
        req.req_type     = whs_pkg::REQ_LOAD;
        req.step_slot    = '0;
        req.step_kind    = whs_pkg::KIND_WAIT;
        req.step_target  = '0;
        req.step_band    = '0;
        req.step_hold_ms = '0;
        req.weight       = '0;
        req.now_ms       = '0;
        ptr_q            = '0;
        completed_q      = 1'b0;
        phase_q          = whs_pkg::PH_START;
        timer_q          = '0;
        heavier_q        = 1'b0;
        count_q          = STEP_W'(1);
        repeat_q         = 1'b0;
        fail_count       = 0;
        src_idle_pct     = 0;
        snk_stall_pct    = 0;
        hold_off_req     = 1'b0;
        clock_ms         = '0;

        // Directed cases: zero-length wait, finished program, pointer wrap,
        // active step reload, in-band hold, time wrap, seek from both sides
        dir_tbl = '{
            with_result(ld(0, whs_pkg::KIND_WAIT, 0, 0, 0), 0, 0, 0, 0),
            with_result(smp(0, 100), 0, 1, 1, 1),
            with_result(smp(32'h7FFF_FFFF, 32'hFFFF_FFFF), 0, 0, 1, 1),
            with_result(ld(0, whs_pkg::KIND_HOLD, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF), 0, 0, 1, 1),
            cfg(1, 1'b1),
            with_result(smp(32'h8000_0000, 0), 1, 0, 0, 0),
            with_result(ld(0, whs_pkg::KIND_HOLD, 0, 31'h7FFF_FFFF, 32'hFFFF_FFFF), 0, 0, 0, 0),
            smp(1, 10),
            smp(32'h8000_0000, 20),
            smp(0, 9),
            ld(0, whs_pkg::KIND_HOLD, 1000, 100, 0),
            smp(1050, 50),
            ld(0, whs_pkg::KIND_HOLD, 1000, 10, 20),
            smp(2000, 100),
            smp(500, 105),
            smp(985, 110),
            smp(995, 125),
            ld(0, whs_pkg::KIND_WAIT, 32'h8000_0000, 0, 30),
            smp(0, 200),
            smp(0, 229),
            smp(0, 230),
            ld(0, whs_pkg::KIND_HOLD, -256, 0, 0),
            smp(-256, 0),
            smp(-1000, 5),
            smp(-100, 6)
        };

        // Hold reset, release it at a falling edge
        repeat (RST_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].is_cfg)
            begin
                wait_idle();
                program_regs(dir_tbl[i].cfg_count, dir_tbl[i].cfg_repeat);
            end
            else
                send_item(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].want);
        end

        // Load every slot before any longer program runs
        for (int s = 0; s < MAX_STEPS_DEF; s++)
            send_item(make_load(STEP_W'(s)), 1'b0, '0);

        // Random phases with changing registers and idling
        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            case (p % 4)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 62;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 62;
                end
                default:
                begin
                    src_idle_pct  = 38;
                    snk_stall_pct = 38;
                end
            endcase
            n_steps = (p % 3 == 0) ? 4'd15 : (p == 1) ? 4'd1 : STEP_W'($urandom_range(2, 14));
            rpt     = (p % 4 != 1);
            if (p == 3)
                clock_ms = 32'hFFFF_FE00;
            program_regs(n_steps, rpt);
            if (p == 4)
                hold_off_req = 1'b1;
            repeat (PHASE_ITEMS)
                send_item(random_item(), 1'b0, '0);
        end

        wait_idle();
        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("PASS weight_hold_step_sequencer_top");
        else
            $display("FAIL weight_hold_step_sequencer_top");
        $finish;
    end

endmodule

[weight_hold_step_sequencer_top.f]
rtl/whs_pkg.sv
rtl/whs_if.sv
rtl/whs_step_mem.sv
rtl/weight_hold_step_sequencer_top.sv
rtl/whs_checker.sv
tb/tb_weight_hold_step_sequencer_top.sv
